@@ rtl/pcpb_pkg.sv @@
// ----------------------------------------------------------------------------
// pcpb_pkg
// Shared types and constants for the patch column post blitter.
// ----------------------------------------------------------------------------
package pcpb_pkg;

    // Screen size limits accepted by the fit check
    localparam int MAX_SCREEN_WIDTH  = 2048;
    localparam int MAX_SCREEN_HEIGHT = 2048;

    // Widths of row and column coordinates once the picture is known to fit
    localparam int ROW_W = $clog2(MAX_SCREEN_HEIGHT);
    localparam int COL_W = $clog2(MAX_SCREEN_WIDTH);

    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 12;
    localparam int OFFSET_W   = 22;
    localparam int SCREEN_W   = 3;

    localparam logic [7:0]          END_OF_COLUMN    = 8'hFF;
    localparam logic [SCREEN_W-1:0] MAX_SCREEN_INDEX = 3'd4;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_PATCH_WIDTH   = 3'd2,
        REG_PATCH_HEIGHT  = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_FLIP          = 3'd6,
        REG_SCREEN_INDEX  = 3'd7
    } cfg_reg_t;

    // Post parser phases
    typedef enum logic [2:0] {
        PH_TOP  = 3'd0,
        PH_LEN  = 3'd1,
        PH_PAD  = 3'd2,
        PH_PIX  = 3'd3,
        PH_TAIL = 3'd4
    } phase_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic signed [15:0]    origin_x;
        logic signed [15:0]    origin_y;
        logic [DIM_W-1:0]      patch_width;
        logic [DIM_W-1:0]      patch_height;
        logic [DIM_W-1:0]      screen_width;
        logic [DIM_W-1:0]      screen_height;
        logic                  flip;
        logic [SCREEN_W-1:0]   screen_index;
        logic                  fits;
    } cfg_t;

    // One pixel write request between parser and address stage
    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [7:0]          value;
        logic [SCREEN_W-1:0] screen;
    } pix_req_t;

endpackage

@@ rtl/pcpb_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pcpb_cfg_regs
// Configuration registers and the picture fit check.
// ----------------------------------------------------------------------------
module pcpb_cfg_regs
    import pcpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic signed [15:0]  origin_x_reg;
    logic signed [15:0]  origin_y_reg;
    logic [DIM_W-1:0]    patch_width_reg;
    logic [DIM_W-1:0]    patch_height_reg;
    logic [DIM_W-1:0]    screen_width_reg;
    logic [DIM_W-1:0]    screen_height_reg;
    logic                flip_reg;
    logic [SCREEN_W-1:0] screen_index_reg;

    logic [15:0] right_edge;
    logic [15:0] bottom_edge;
    logic        fits;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            patch_width_reg   <= '0;
            patch_height_reg  <= '0;
            screen_width_reg  <= DIM_W'(320);
            screen_height_reg <= DIM_W'(200);
            flip_reg          <= 1'b0;
            screen_index_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ORIGIN_X:      origin_x_reg      <= cfg_data;
                REG_ORIGIN_Y:      origin_y_reg      <= cfg_data;
                REG_PATCH_WIDTH:   patch_width_reg   <= cfg_data[DIM_W-1:0];
                REG_PATCH_HEIGHT:  patch_height_reg  <= cfg_data[DIM_W-1:0];
                REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[DIM_W-1:0];
                REG_FLIP:          flip_reg          <= cfg_data[0];
                REG_SCREEN_INDEX:  screen_index_reg  <= cfg_data[SCREEN_W-1:0];
                default:           ;
            endcase
        end
    end

    // Check that the whole picture lands on a valid screen
    always_comb
    begin
        right_edge  = {1'b0, origin_x_reg[14:0]} + {4'b0, patch_width_reg};
        bottom_edge = {1'b0, origin_y_reg[14:0]} + {4'b0, patch_height_reg};
        fits = 1'b1;
        if (screen_index_reg > MAX_SCREEN_INDEX)
            fits = 1'b0;
        if ({1'b0, screen_width_reg} > 13'(MAX_SCREEN_WIDTH))
            fits = 1'b0;
        if ({1'b0, screen_height_reg} > 13'(MAX_SCREEN_HEIGHT))
            fits = 1'b0;
        if (origin_x_reg[15] || origin_y_reg[15])
            fits = 1'b0;
        if (right_edge > {4'b0, screen_width_reg})
            fits = 1'b0;
        if (bottom_edge > {4'b0, screen_height_reg})
            fits = 1'b0;
    end

    assign cfg.origin_x      = origin_x_reg;
    assign cfg.origin_y      = origin_y_reg;
    assign cfg.patch_width   = patch_width_reg;
    assign cfg.patch_height  = patch_height_reg;
    assign cfg.screen_width  = screen_width_reg;
    assign cfg.screen_height = screen_height_reg;
    assign cfg.flip          = flip_reg;
    assign cfg.screen_index  = screen_index_reg;
    assign cfg.fits          = fits;

endmodule

@@ rtl/pcpb_parser.sv @@
// ----------------------------------------------------------------------------
// pcpb_parser
// Post stream parser: tracks column, post row and byte count, and turns
// each visible pixel byte into a registered pixel request.
// ----------------------------------------------------------------------------
module pcpb_parser
    import pcpb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       patch_start,
    output logic       req_valid,
    output pix_req_t   req,
    input  logic       req_take
);

    phase_t           phase_reg,      phase_next;
    logic [DIM_W-1:0] col_reg,        col_next;
    logic [DIM_W-1:0] post_row_reg,   post_row_next;
    logic [7:0]       bytes_left_reg, bytes_left_next;
    logic             req_valid_reg,  req_valid_next;
    pix_req_t         req_reg,        req_next;

    logic             accept;
    phase_t           eff_phase;
    logic [DIM_W-1:0] eff_col;
    logic [7:0]       bytes_dec;
    logic [15:0]      row_full;
    logic [15:0]      col_full;
    logic             pix_hit;

    // Stall only when the request slot is full and cannot drain
    assign in_stall = req_valid_reg && !req_take;
    assign accept   = in_valid && !in_stall;

    // A new picture restarts the column count and the post phase
    assign eff_phase = patch_start ? PH_TOP : phase_reg;
    assign eff_col   = patch_start ? '0 : col_reg;
    assign bytes_dec = bytes_left_reg - 8'd1;

    // Next state of the parser
    always_comb
    begin
        phase_next      = phase_reg;
        col_next        = col_reg;
        post_row_next   = post_row_reg;
        bytes_left_next = bytes_left_reg;
        if (accept)
        begin
            col_next   = eff_col;
            phase_next = eff_phase;
            case (eff_phase)
                PH_LEN:
                begin
                    bytes_left_next = data_byte;
                    phase_next      = PH_PAD;
                end
                PH_PAD:
                begin
                    phase_next = (bytes_left_reg != 8'd0) ? PH_PIX : PH_TAIL;
                end
                PH_PIX:
                begin
                    post_row_next   = post_row_reg + DIM_W'(1);
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 8'd0)
                        phase_next = PH_TAIL;
                end
                PH_TAIL:
                begin
                    phase_next = PH_TOP;
                end
                default:
                begin
                    if (data_byte == END_OF_COLUMN)
                    begin
                        if (eff_col < cfg.patch_width)
                            col_next = eff_col + DIM_W'(1);
                        phase_next = PH_TOP;
                    end
                    else
                    begin
                        post_row_next = {4'b0, data_byte};
                        phase_next    = PH_LEN;
                    end
                end
            endcase
        end
    end

    // Screen position of the current pixel byte and the request it makes
    always_comb
    begin
        row_full = {1'b0, cfg.origin_y[14:0]} + {4'b0, post_row_reg};
        if (cfg.flip)
            col_full = 16'({1'b0, cfg.origin_x[14:0]} + {4'b0, cfg.patch_width}
                           - 16'd1 - {4'b0, eff_col});
        else
            col_full = 16'({1'b0, cfg.origin_x[14:0]} + {4'b0, eff_col});

        pix_hit = accept && (eff_phase == PH_PIX) && cfg.fits
                  && (eff_col < cfg.patch_width)
                  && (row_full < {4'b0, cfg.screen_height});

        req_next.row    = row_full[ROW_W-1:0];
        req_next.col    = col_full[COL_W-1:0];
        req_next.value  = data_byte;
        req_next.screen = cfg.screen_index;

        if (pix_hit)
            req_valid_next = 1'b1;
        else if (req_take)
            req_valid_next = 1'b0;
        else
            req_valid_next = req_valid_reg;
    end

    // Advance parser state and request flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TOP;
            col_reg        <= '0;
            post_row_reg   <= '0;
            bytes_left_reg <= '0;
            req_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            col_reg        <= col_next;
            post_row_reg   <= post_row_next;
            bytes_left_reg <= bytes_left_next;
            req_valid_reg  <= req_valid_next;
        end
    end

    // Hold the request payload until a new pixel replaces it
    always_ff @(posedge clk)
    begin
        if (pix_hit)
            req_reg <= req_next;
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

`ifndef SYNTH
    a_len_then_pad: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eff_phase == PH_LEN) |=> (phase_reg == PH_PAD))
        else $error("length byte not followed by pad phase");

    a_pix_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIX) |-> (bytes_left_reg != 8'd0))
        else $error("pixel phase entered with no bytes left");
`endif

endmodule

@@ rtl/pcpb_addr_stage.sv @@
// ----------------------------------------------------------------------------
// pcpb_addr_stage
// Forms the framebuffer offset row * screen_width + column and holds the
// pixel write in the output register.
// ----------------------------------------------------------------------------
module pcpb_addr_stage
    import pcpb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                req_valid,
    input  pix_req_t            req,
    output logic                req_take,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [OFFSET_W-1:0] pixel_offset,
    output logic [7:0]          pixel_value,
    output logic [SCREEN_W-1:0] target_screen
);

    localparam int PROD_W = ROW_W + DIM_W;

    logic                out_valid_reg, out_valid_next;
    logic [OFFSET_W-1:0] offset_reg,    offset_next;
    logic [7:0]          value_reg;
    logic [SCREEN_W-1:0] screen_reg;
    logic [PROD_W-1:0]   product;
    logic                load;

    // Output register is free when empty or being drained
    assign req_take = !out_valid_reg || !out_stall;
    assign load     = req_take && req_valid;

    // Multiply-add for the pixel offset
    always_comb
    begin
        product        = PROD_W'(req.row) * PROD_W'(cfg.screen_width);
        offset_next    = OFFSET_W'(product + PROD_W'(req.col));
        out_valid_next = req_take ? req_valid : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Capture the write when the slot advances
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            offset_reg <= offset_next;
            value_reg  <= req.value;
            screen_reg <= req.screen;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pixel_offset  = offset_reg;
    assign pixel_value   = value_reg;
    assign target_screen = screen_reg;

endmodule

@@ rtl/patch_column_post_blitter.sv @@
// ----------------------------------------------------------------------------
// patch_column_post_blitter
// Turns the column post bytes of a masked picture into pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one picture byte per request in
//   column order; patch_start marks the first byte of a picture.
//   Output channel (out_valid / out_stall): one pixel write per visible
//   pixel byte: framebuffer offset, palette index and screen number.
//   Configuration (cfg_we / cfg_index / cfg_data): origin, picture and
//   screen sizes, flip and screen number; write only while idle.
// Timing:
//   One byte is taken every cycle while in_stall is low. The clock edge that
//   takes a pixel byte registers a request in the parser; the output
//   register then loads the offset multiply-add from that request and
//   shows the write on out_valid.
//   Bytes that make no pixel pass without any output request.
// Reset:
//   Parser returns to expecting a top row byte, column count cleared,
//   registers to their defaults (screen 320 x 200), no write pending.
// Back-pressure:
//   While out_stall is high the write is held; in_stall rises only when
//   both the request slot and the output register are full.
// ----------------------------------------------------------------------------
module patch_column_post_blitter
    import pcpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  patch_start,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OFFSET_W-1:0]   pixel_offset,
    output logic [7:0]            pixel_value,
    output logic [SCREEN_W-1:0]   target_screen
);

    cfg_t     cfg;
    logic     req_valid;
    pix_req_t req;
    logic     req_take;

    pcpb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pcpb_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .patch_start (patch_start),
        .req_valid   (req_valid),
        .req         (req),
        .req_take    (req_take)
    );

    pcpb_addr_stage u_addr_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .req_valid     (req_valid),
        .req           (req),
        .req_take      (req_take),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_offset  (pixel_offset),
        .pixel_value   (pixel_value),
        .target_screen (target_screen)
    );

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (req_valid && out_valid && out_stall))
        else $error("input stalled while pipeline can drain");

    a_screen_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_screen <= MAX_SCREEN_INDEX))
        else $error("pixel write to a screen that does not exist");
`endif

endmodule
